// ===== rtl/ddf_pkg.sv =====
`timescale 1ns / 1ps
package ddf_pkg;

    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 4;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 9;
    localparam int FONT_W    = 6;
    localparam int CODE_W    = 6;
    localparam int XCOL_W    = 10;
    localparam int PITCH_W   = 5;
    localparam int BIT_CNT_W = 5;
    localparam int DIGIT_W   = 4;

    localparam logic [CODE_W-1:0] CODE_SPACE = 6'd32;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic [COL_W-1:0]   start_column;
        logic [ROW_W-1:0]   row;
        logic [FONT_W-1:0]  font_height;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic [XCOL_W-1:0] column;
        logic [ROW_W-1:0]  row_out;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic dabble;
        logic dshift;
    } t_bcd_cmd;

endpackage

// ===== rtl/decimal_digit_formatter.sv =====
`timescale 1ns / 1ps
// Prints a 32-bit unsigned value as a field of n = min(digit_count, MAX_DIGITS)
// decimal characters (leading zeros blanked, last position always a digit). An
// item is taken when start is high and busy is low; with n > 0 the block stays
// busy through the bit-serial binary to BCD conversion (one value bit per cycle),
// the steps that shift the top wanted digit into place, and the emit state that
// gives one character per cycle. Results come on consecutive cycles, each held
// for one cycle with o_strobe; the receiver cannot stall them. A width of 0 gives
// no results and leaves the block idle.
module decimal_digit_formatter
    import ddf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_data,
    output logic      o_strobe,
    output t_out_item o_data
);

    t_bcd_cmd           cmd;
    logic [DIGIT_W-1:0] top_digit;

    ddf_bcd #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_bcd (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_value    (i_data.value),
        .o_top_digit(top_digit)
    );

    ddf_ctrl #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_data     (i_data),
        .i_top_digit(top_digit),
        .o_cmd      (cmd),
        .o_strobe   (o_strobe),
        .o_data     (o_data)
    );

endmodule

// ===== rtl/ddf_bcd.sv =====
`timescale 1ns / 1ps
module ddf_bcd
    import ddf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic               i_clk,
    input  t_bcd_cmd           i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output logic [DIGIT_W-1:0] o_top_digit
);

    localparam int BCD_W = DIGIT_W * MAX_DIGITS;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   adj;

    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // load, shift in one binary bit per cycle, then step out one digit per cycle
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.dabble) begin
            r_bin <= r_bin << 1;
            r_bcd <= {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end else if (i_cmd.dshift) begin
            r_bcd <= r_bcd << DIGIT_W;
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

endmodule

// ===== rtl/ddf_ctrl.sv =====
`timescale 1ns / 1ps
module ddf_ctrl
    import ddf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_data,
    input  logic [DIGIT_W-1:0] i_top_digit,
    output t_bcd_cmd           o_cmd,
    output logic               o_strobe,
    output t_out_item          o_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [COUNT_W-1:0]   MAX_CNT  = COUNT_W'(MAX_DIGITS);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

    logic [1:0]           r_state;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0]   r_count;
    logic [XCOL_W-1:0]    r_col;
    logic [ROW_W-1:0]     r_row;
    logic [PITCH_W-1:0]   r_pitch;
    logic                 r_show;
    logic                 r_strobe;
    t_out_item            r_out;

    logic                 accept;
    logic [COUNT_W-1:0]   count_sat;
    logic [BIT_CNT_W-1:0] align_n;
    logic                 emit_last;
    logic                 blank;

    assign accept    = start && (r_state == ST_IDLE);
    assign count_sat = (i_data.digit_count > MAX_CNT) ? MAX_CNT : i_data.digit_count;
    assign align_n   = BIT_CNT_W'(MAX_DIGITS) - BIT_CNT_W'(r_count);
    assign emit_last = (r_cnt == BIT_CNT_W'(1));
    assign blank     = (i_top_digit == '0) && !r_show && !emit_last;

    always_comb begin
        o_cmd.load   = accept;
        o_cmd.dabble = (r_state == ST_CONV);
        o_cmd.dshift = (r_state == ST_ALIGN) || (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_EMIT);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (count_sat != '0)) begin
                        r_state <= ST_CONV;
                        r_cnt   <= '0;
                    end
                end
                ST_CONV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_BIT) begin
                        if (align_n == '0) begin
                            r_state <= ST_EMIT;
                            r_cnt   <= BIT_CNT_W'(r_count);
                        end else begin
                            r_state <= ST_ALIGN;
                            r_cnt   <= align_n;
                        end
                    end
                end
                ST_ALIGN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == BIT_CNT_W'(1)) begin
                        r_state <= ST_EMIT;
                        r_cnt   <= BIT_CNT_W'(r_count);
                    end
                end
                ST_EMIT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (emit_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_count <= count_sat;
            r_col   <= XCOL_W'(i_data.start_column);
            r_row   <= i_data.row;
            r_pitch <= i_data.font_height[FONT_W-1:1];
            r_show  <= 1'b0;
        end else if (r_state == ST_EMIT) begin
            r_col <= r_col + XCOL_W'(r_pitch);
            if (!blank) begin
                r_show <= 1'b1;
            end
            r_out.char_code <= blank ? CODE_SPACE : (CODE_ZERO + CODE_W'(i_top_digit));
            r_out.column    <= r_col;
            r_out.row_out   <= r_row;
            r_out.last      <= emit_last;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_data   = r_out;

endmodule

// ===== rtl/ddf_checker.sv =====
`timescale 1ns / 1ps
module ddf_checker
    import ddf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_data,
    input logic      o_strobe,
    input t_out_item o_data
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_data.digit_count != '0) |=> busy)
        else $error("not busy after accepting a nonempty item");

    a_no_result_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result right after an accepted item");

    a_results_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_data.last |=> o_strobe)
        else $error("gap inside a field");

    a_field_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_data.last |=> !o_strobe)
        else $error("result after the last position");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_data.char_code == CODE_SPACE) ||
                     ((o_data.char_code >= CODE_ZERO) && (o_data.char_code <= 6'd57)))
        else $error("character code out of range");

endmodule

bind decimal_digit_formatter ddf_checker u_ddf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_data  (i_data),
    .o_strobe(o_strobe),
    .o_data  (o_data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ddf_pkg::*;

    localparam int MAX_DIGITS = 10;
    localparam int TAIL_ITEMS = 40;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_queued_field;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  field_req = '0;
    logic      o_strobe;
    t_out_item o_data;

    t_queued_field field_requests[$];
    t_out_item     expected_chars[$];

    logic        item_taken = 1'b0;
    logic        staged = 1'b0;
    t_in_item    staged_req = '0;
    int unsigned gap_left = 0;

    int errors = 0;
    int items_taken = 0;
    int blank_fields = 0;
    int chars_checked = 0;

    decimal_digit_formatter #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (field_req),
        .o_strobe(o_strobe),
        .o_data  (o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void predict_field(input t_in_item it);
        logic [3:0]         dig[MAX_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 n;
        bit                 lit;
        t_out_item          ch;
        rest = it.value;
        for (int p = 0; p < MAX_DIGITS; p++) begin
            dig[p] = 4'(rest % 10);
            rest = rest / 10;
        end
        n = (it.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(it.digit_count);
        lit = 1'b0;
        for (int t = 0; t < n; t++) begin
            ch.last = (t == n - 1);
            if (!lit && !ch.last && dig[n - 1 - t] == 4'd0) begin
                ch.char_code = CODE_SPACE;
            end else begin
                lit = 1'b1;
                ch.char_code = CODE_ZERO + CODE_W'(dig[n - 1 - t]);
            end
            ch.column = XCOL_W'(int'(it.start_column) + int'(it.font_height >> 1) * t);
            ch.row_out = it.row;
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void add_field(input logic [VALUE_W-1:0] value,
                                      input int count, input int col,
                                      input int row, input int font,
                                      input int unsigned gap);
        t_queued_field q;
        q.item.value = value;
        q.item.digit_count = COUNT_W'(count);
        q.item.start_column = COL_W'(col);
        q.item.row = ROW_W'(row);
        q.item.font_height = FONT_W'(font);
        q.gap = gap;
        field_requests.push_back(q);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned k;
        int unsigned lead;
        logic [VALUE_W-1:0] scale;
        scale = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 9: return $urandom;
            3, 4: return $urandom_range(0, 999);
            5, 6: begin
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++) scale = scale * 10;
                lead = (k == 9) ? $urandom_range(1, 4) : $urandom_range(1, 9);
                return scale * lead + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
            end
            7: return $urandom_range(0, 9);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic int pick_count();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(11, 15);
        return $urandom_range(1, 10);
    endfunction

    always @(negedge i_clk) begin : drive
        t_queued_field nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // hold until taken
        end else if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (staged) begin
            start <= 1'b1;
            field_req <= staged_req;
            staged <= 1'b0;
        end else if (field_requests.size() != 0) begin
            nxt = field_requests.pop_front();
            if (nxt.gap != 0) begin
                start <= 1'b0;
                gap_left <= nxt.gap - 1;
                staged_req <= nxt.item;
                staged <= 1'b1;
            end else begin
                start <= 1'b1;
                field_req <= nxt.item;
            end
        end else begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : watch
        t_out_item want;
        item_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            predict_field(field_req);
            items_taken++;
            if (field_req.digit_count == 0) blank_fields++;
        end
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected character code=%0d column=%0d row=%0d last=%0b",
                         $time, o_data.char_code, o_data.column, o_data.row_out,
                         o_data.last);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_data.char_code !== want.char_code || o_data.column !== want.column ||
                    o_data.row_out !== want.row_out || o_data.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch expected code=%0d column=%0d row=%0d last=%0b",
                             $time, want.char_code, want.column, want.row_out, want.last);
                    $display("%0t:          actual   code=%0d column=%0d row=%0d last=%0b",
                             $time, o_data.char_code, o_data.column, o_data.row_out,
                             o_data.last);
                end
            end
        end
    end

    initial begin
        int unsigned gap;
        // leading zero blanking, dropped high digits, last digit always shown
        add_field(32'd0, 1, 0, 0, 1, 0);
        add_field(32'd0, 10, 511, 511, 32, 0);
        add_field(32'hFFFF_FFFF, 10, 0, 511, 32, 0);
        add_field(32'hFFFF_FFFF, 15, 511, 0, 63, 0);
        add_field(32'd1_000_000_000, 10, 100, 200, 20, 0);
        add_field(32'd12345, 3, 7, 9, 8, 0);
        add_field(32'd1005, 3, 300, 3, 17, 0);
        add_field(32'd7000, 3, 12, 34, 16, 0);
        add_field(32'd10, 5, 64, 64, 0, 0);
        add_field(32'd42, 0, 10, 10, 10, 0);
        add_field(32'd999, 0, 0, 0, 0, 0);
        add_field(32'd5, 1, 511, 511, 63, 0);
        add_field(32'd1234567890, 11, 1, 2, 31, 0);
        add_field(32'd987654321, 12, 3, 4, 5, 0);
        add_field(32'd100, 3, 255, 256, 2, 0);
        add_field(32'd100, 10, 256, 255, 3, 0);
        add_field(32'd2147483648, 10, 170, 341, 42, 0);
        add_field(32'd9, 2, 85, 170, 21, 0);
        add_field(32'd90, 2, 0, 0, 1, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gap = 0;
            if (i < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 8);
            add_field(pick_value(), pick_count(), $urandom_range(0, 511),
                      $urandom_range(0, 511),
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(1, 32),
                      gap);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (field_requests.size() != 0 || staged || gap_left != 0 || start)
            @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Fields taken: %0d (%0d of zero width), characters checked: %0d",
                 items_taken, blank_fields, chars_checked);
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d characters outstanding", $time,
                 expected_chars.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ddf_pkg.sv
rtl/ddf_bcd.sv
rtl/ddf_ctrl.sv
rtl/decimal_digit_formatter.sv
rtl/ddf_checker.sv
test/tb_top.sv
